/* design/iiv_pkg.sv */
// shared types and codes for the indexed insert vector unit
package iiv_pkg;

  // default number of entries in the list
  localparam int unsigned DEFAULT_CAPACITY = 32;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_POP    = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // control broadcast to every storage stage
  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_pos;
    logic [POS_W-1:0] rd_pos;
  } stage_ctrl_t;

endpackage

/* design/iiv_cell.sv */
// one storage stage of the list: holds one word, takes it from its lower neighbor on a shift
module iiv_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                          clk,
  input  iiv_pkg::stage_ctrl_t          ctrl,
  input  logic [iiv_pkg::WORD_W-1:0]    prev_word,
  input  logic [iiv_pkg::WORD_W-1:0]    value,
  output logic [iiv_pkg::WORD_W-1:0]    word,
  output logic [iiv_pkg::WORD_W-1:0]    rd_word
);
  import iiv_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

  // load at the write position, shift up above it
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      if (ctrl.wr_pos == MY_POS) begin
        word <= value;
      end else if (MY_POS > ctrl.wr_pos) begin
        word <= prev_word;
      end
    end
  end

  // drive the word only when this stage is addressed
  assign rd_word = (ctrl.rd_pos == MY_POS) ? word : '0;

endmodule

/* design/indexed_insert_vector_unit.sv */
// top level of the indexed insert vector unit: request decode, storage row and result register
// the result of each request is loaded into the output register when the request is accepted
// throughput: one request per cycle while results are taken; an accepted insert shifts the stages above its position
// the next request is taken while a result waits, as long as the output register frees up
// reset clears the entry count and the output valid; stored words are undefined until written
module indexed_insert_vector_unit #(
  parameter int unsigned CAPACITY = iiv_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero[39:38]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_value[31:0], count[37:32], zero[39:38]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import iiv_pkg::*;

  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W  = 7;
  localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAPACITY);

  // request fields
  kind_t             kind;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] value;

  assign kind     = kind_t'(s_tuser);
  assign position = s_tdata[POS_W-1:0];
  assign value    = s_tdata[POS_W +: WORD_W];

  // state
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [EXT_W-1:0]  fill_ext;
  logic [EXT_W-1:0]  fill_next_ext;
  logic [EXT_W-1:0]  pos_ext;

  logic accept;
  logic rd_hit;
  status_t status_next;
  stage_ctrl_t ctrl;

  // result register
  logic [WORD_W-1:0]  res_value;
  status_t            res_status;
  logic [COUNT_W-1:0] res_count;
  logic [WORD_W-1:0]  rd_value;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign fill_ext = EXT_W'(fill);
  assign pos_ext  = EXT_W'(position);

  // request decode
  always_comb begin
    status_next = ST_OK;
    fill_next   = fill;
    ctrl.wr_en  = 1'b0;
    ctrl.wr_pos = POS_W'(fill);
    ctrl.rd_pos = position;
    rd_hit      = 1'b0;
    unique case (kind)
      KIND_PUSH: begin
        if (fill_ext >= CAP_EXT) begin
          status_next = ST_FULL;
        end else begin
          ctrl.wr_en = accept;
          fill_next  = fill + 1'b1;
        end
      end
      KIND_INSERT: begin
        ctrl.wr_pos = position;
        if (pos_ext > fill_ext) begin
          status_next = ST_RANGE;
        end else if (fill_ext >= CAP_EXT) begin
          status_next = ST_FULL;
        end else begin
          ctrl.wr_en = accept;
          fill_next  = fill + 1'b1;
        end
      end
      KIND_POP: begin
        if (fill == '0) begin
          status_next = ST_EMPTY;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      KIND_READ: begin
        if (fill == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_ext >= fill_ext) begin
          status_next = ST_RANGE;
        end else begin
          rd_hit = 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign fill_next_ext = EXT_W'(fill_next);

  // storage row
  logic [WORD_W-1:0] words    [CAPACITY];
  logic [WORD_W-1:0] rd_words [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_stage
    logic [WORD_W-1:0] prev_word;
    if (i == 0) begin : g_first
      assign prev_word = value;
    end else begin : g_rest
      assign prev_word = words[i-1];
    end
    iiv_cell #(
      .INDEX (i)
    ) u_stage (
      .clk       (clk),
      .ctrl      (ctrl),
      .prev_word (prev_word),
      .value     (value),
      .word      (words[i]),
      .rd_word   (rd_words[i])
    );
  end

  // combine the addressed stage output
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | rd_words[i];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_value  <= rd_hit ? rd_value : '0;
      res_status <= status_next;
      res_count  <= fill_next_ext[COUNT_W-1:0];
    end
  end

  assign m_tdata = {2'b00, res_count, res_value};
  assign m_tuser = res_status;

endmodule

/* tb/iiv_check_pkg.sv */
// scoreboard class that predicts and checks the results of the indexed insert vector unit
`timescale 1ns / 100ps

package iiv_check_pkg;
  import iiv_pkg::*;

  class list_scoreboard;
    // predicted contents of the list and its entry count
    logic [WORD_W-1:0]  entries [64];
    int unsigned        fill;
    int unsigned        capacity;

    // results still owed by the block, oldest first
    logic [WORD_W-1:0]  owed_value [$];
    status_t            owed_status [$];
    logic [COUNT_W-1:0] owed_count [$];

    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        kind_seen [4];
    int unsigned        status_seen [4];

    function new(int unsigned cap);
      capacity   = cap;
      fill       = 0;
      mismatches = 0;
      checked    = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function int unsigned pending();
      return owed_value.size();
    endfunction

    // apply one accepted request to the predicted list and queue its result
    function void note_request(kind_t kind, logic [POS_W-1:0] pos, logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] rd;
      status_t           st;
      int unsigned       i;
      rd = '0;
      st = ST_OK;
      case (kind)
        KIND_PUSH: begin
          if (fill >= capacity) begin
            st = ST_FULL;
          end else begin
            entries[fill] = word;
            fill++;
          end
        end
        KIND_INSERT: begin
          // the range check wins over the full check
          if (pos > fill) begin
            st = ST_RANGE;
          end else if (fill >= capacity) begin
            st = ST_FULL;
          end else begin
            for (i = fill; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = word;
            fill++;
          end
        end
        KIND_POP: begin
          if (fill == 0) st = ST_EMPTY;
          else fill--;
        end
        default: begin
          if (fill == 0) st = ST_EMPTY;
          else if (pos >= fill) st = ST_RANGE;
          else rd = entries[pos];
        end
      endcase
      owed_value  = {owed_value, rd};
      owed_status = {owed_status, st};
      owed_count  = {owed_count, fill[COUNT_W-1:0]};
      kind_seen[kind]++;
      status_seen[st]++;
    endfunction

    task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    // compare one returned result with the oldest owed one
    task check_result(logic [WORD_W-1:0] value, status_t st, logic [COUNT_W-1:0] cnt);
      logic [WORD_W-1:0]  want_value;
      status_t            want_status;
      logic [COUNT_W-1:0] want_count;
      checked++;
      if (owed_value.size() == 0) begin
        report_mismatch("result with no request outstanding", value, '0);
      end else begin
        want_value  = owed_value.pop_front();
        want_status = owed_status.pop_front();
        want_count  = owed_count.pop_front();
        if (value !== want_value) report_mismatch("read_value", value, want_value);
        if (st !== want_status) report_mismatch("status", {30'b0, st}, {30'b0, want_status});
        if (cnt !== want_count) report_mismatch("count", {26'b0, cnt}, {26'b0, want_count});
      end
    endtask
  endclass

endpackage

/* tb/tb_indexed_insert_vector_unit.sv */
// testbench top for the indexed insert vector unit: directed and random request streams
`timescale 1ns / 100ps

module tb_indexed_insert_vector_unit;
  import iiv_pkg::*;
  import iiv_check_pkg::*;

  localparam int unsigned CAPACITY    = DEFAULT_CAPACITY;
  localparam int unsigned RANDOM_REQS = 900;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef enum {GROW_LIST, SHRINK_LIST, MIXED_OPS, RANDOM_NOISE} pattern_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // position[5:0], value[37:6], zero[39:38]
  logic [1:0]  s_tuser;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // read_value[31:0], count[37:32], zero[39:38]
  logic [1:0]  m_tuser;   // status[1:0]

  list_scoreboard sb;
  int unsigned    issued;
  bit             quiet_phase;
  bit             held;

  indexed_insert_vector_unit #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #500000;
    $display("Mismatches found");
    $finish;
  end

  // word with the sign and all-ones extremes mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // offer one request after a random gap and wait until it is taken
  task automatic send_request(kind_t kind, logic [POS_W-1:0] pos, logic [WORD_W-1:0] word);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, word, pos};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, pos, word);
    issued++;
  endtask

  // pick one request that fits the current pattern
  task automatic send_shaped(pattern_t pattern);
    kind_t            kind;
    logic [POS_W-1:0] pos;
    int unsigned      r;
    r    = $urandom_range(0, 9);
    pos  = POS_W'($urandom_range(0, 63));
    kind = kind_t'($urandom_range(0, 3));
    case (pattern)
      GROW_LIST: begin
        if (r < 5) begin
          kind = KIND_PUSH;
        end else if (r < 9) begin
          kind = KIND_INSERT;
          if (r == 8 && sb.fill >= CAPACITY) pos = POS_W'($urandom_range(sb.fill + 1, 63));
          else pos = POS_W'($urandom_range(0, sb.fill));
        end else begin
          kind = KIND_READ;
          pos  = (sb.fill == 0) ? '0 : POS_W'($urandom_range(0, sb.fill - 1));
        end
      end
      SHRINK_LIST: begin
        if (r < 6) begin
          kind = KIND_POP;
        end else begin
          kind = KIND_READ;
          if (r != 9) pos = (sb.fill == 0) ? '0 : POS_W'($urandom_range(0, sb.fill - 1));
        end
      end
      MIXED_OPS: begin
        if (r < 8) pos = POS_W'($urandom_range(0, sb.fill + 1));
      end
      default: ;
    endcase
    send_request(kind, pos, pick_word());
  endtask

  // result check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready && sb != null) begin
      sb.check_result(m_tdata[31:0], status_t'(m_tuser), m_tdata[37:32]);
    end
  end

  // result side: random stalls, plus one long hold-off that backs up the block
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    held     = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 5);
      if (!held && sb.checked >= 300) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // request side and end of run
  initial begin
    pattern_t    pattern;
    int unsigned waited;
    bit          first;
    sb          = new(CAPACITY);
    issued      = 0;
    quiet_phase = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = KIND_PUSH;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty list, out of range inserts, extremes, insert at front, end and middle
    send_request(KIND_READ,   6'd0,  32'h1234_5678);
    send_request(KIND_READ,   6'd63, 32'h0);
    send_request(KIND_POP,    6'd0,  32'h0);
    send_request(KIND_INSERT, 6'd1,  32'hDEAD_BEEF);
    send_request(KIND_INSERT, 6'd63, 32'hFFFF_FFFF);
    send_request(KIND_PUSH,   6'd63, 32'h7FFF_FFFF);
    send_request(KIND_PUSH,   6'd0,  32'h8000_0000);
    send_request(KIND_INSERT, 6'd0,  32'hFFFF_FFFF);
    send_request(KIND_INSERT, 6'd3,  32'h0000_0000);
    send_request(KIND_INSERT, 6'd2,  32'hA5A5_A5A5);
    send_request(KIND_INSERT, 6'd6,  32'h0000_0001);
    send_request(KIND_READ,   6'd0,  32'h0);
    send_request(KIND_READ,   6'd4,  32'h0);
    send_request(KIND_READ,   6'd5,  32'h0);
    send_request(KIND_READ,   6'd63, 32'h0);
    send_request(KIND_POP,    6'd21, 32'hFFFF_FFFF);
    send_request(KIND_READ,   6'd4,  32'h0);
    send_request(KIND_INSERT, 6'd1,  32'h5A5A_5A5A);
    send_request(KIND_READ,   6'd1,  32'h0);

    // random bursts, the first one filling the list up to full
    first = 1'b1;
    while (issued < RANDOM_REQS + 19) begin
      quiet_phase = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 5))
        0, 1:    pattern = GROW_LIST;
        2, 3:    pattern = SHRINK_LIST;
        4:       pattern = MIXED_OPS;
        default: pattern = RANDOM_NOISE;
      endcase
      if (first) pattern = GROW_LIST;
      first = 1'b0;
      case (pattern)
        GROW_LIST: begin
          while (sb.fill < CAPACITY) send_shaped(pattern);
          repeat ($urandom_range(1, 4)) send_shaped(pattern);
        end
        SHRINK_LIST: begin
          while (sb.fill > 0) send_shaped(pattern);
          repeat ($urandom_range(1, 3)) send_shaped(pattern);
        end
        default: begin
          repeat ($urandom_range(5, 40)) send_shaped(pattern);
        end
      endcase
    end
    s_tvalid <= 1'b0;
    quiet_phase = 1'b0;

    // drain outstanding results
    waited = 0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("results never returned", sb.pending(), 0);

    $display("covered %0d requests: %0d push, %0d insert, %0d pop, %0d read",
             issued, sb.kind_seen[KIND_PUSH], sb.kind_seen[KIND_INSERT],
             sb.kind_seen[KIND_POP], sb.kind_seen[KIND_READ]);
    $display("outcomes: %0d ok, %0d out of range, %0d empty, %0d full; %0d results checked",
             sb.status_seen[ST_OK], sb.status_seen[ST_RANGE], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_FULL], sb.checked);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
